// ===== rtl/spam_pkg.sv =====
// shared types and codes for the sparse polynomial add and multiply block
package spam_pkg;

  localparam int OP_BITS    = 3;
  localparam int ACC_BITS   = 40;
  localparam int POUT_BITS  = 9;
  localparam int EMIT_BITS  = 7;
  localparam int EMIT_LIMIT = 64;

  typedef enum logic [OP_BITS-1:0] {
    OP_LOAD_A  = 3'd0,
    OP_LOAD_B  = 3'd1,
    OP_SUM     = 3'd2,
    OP_PRODUCT = 3'd3,
    OP_CLEAR   = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LSCAN,
    S_LSHIFT,
    S_LINS,
    S_SUM,
    S_PMUL,
    S_PACC,
    S_PEND
  } state_t;

endpackage

// ===== rtl/sparse_polynomial_add_multiply.sv =====
// sparse polynomial add and multiply: term tables, merge and product unit
//
// channel  ports                                   handshake
// in       in_opcode in_coeff_in in_power_in       start high while busy low
// out      out_coeff_out out_power_out out_term_valid out_last_item out_status
//                                                  out_valid, one cycle per beat
//
// load: search for the power (merge if found), else shift one table entry a cycle, then insert
// sum: one beat a cycle, one per merged term
// product: each pass over all pairs runs a multiply then an accumulate step per pair,
//   then an end step; one pass finds the top power and one more per emitted term
// reset clears the state, the counts and out_valid only; table entries are undefined until written
// the receiver cannot stall, so every beat is taken in its own cycle
module sparse_polynomial_add_multiply import spam_pkg::*; #(
  parameter int MAX_TERMS  = 8,
  parameter int COEFF_BITS = 16,
  parameter int POWER_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_BITS-1:0]   in_opcode,
  input  logic signed [15:0]   in_coeff_in,
  input  logic [7:0]           in_power_in,
  output logic                 out_valid,
  output logic signed [ACC_BITS-1:0] out_coeff_out,
  output logic [POUT_BITS-1:0] out_power_out,
  output logic                 out_term_valid,
  output logic                 out_last_item,
  output logic                 out_status
);

  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int CB = COEFF_BITS;
  localparam int PB = POWER_BITS;
  localparam int PW = POWER_BITS + 1;
  localparam longint CHI = (64'sd1 <<< (CB - 1)) - 64'sd1;
  localparam longint CLO = -CHI - 64'sd1;
  localparam longint AHI = (64'sd1 <<< (ACC_BITS - 1)) - 64'sd1;
  localparam longint ALO = -AHI - 64'sd1;

  logic signed [CB-1:0] a_c_r [MAX_TERMS];
  logic [PB-1:0]        a_p_r [MAX_TERMS];
  logic signed [CB-1:0] b_c_r [MAX_TERMS];
  logic [PB-1:0]        b_p_r [MAX_TERMS];
  logic [CW-1:0]        acnt_r, acnt_nxt, bcnt_r, bcnt_nxt;

  state_t               state_r, state_nxt;
  logic                 sel_r, sel_nxt;
  logic signed [CB-1:0] lc_r, lc_nxt;
  logic [PB-1:0]        lp_r, lp_nxt;
  logic [CW-1:0]        i_r, i_nxt, j_r, j_nxt, sh_r, sh_nxt;

  logic signed [ACC_BITS-1:0] mul_r, mul_nxt, acc_r, acc_nxt;
  logic [PW-1:0]        pp_r, pp_nxt, tgt_r, tgt_nxt, nx_r, nx_nxt;
  logic                 first_r, first_nxt, hit_r, hit_nxt, nf_r, nf_nxt;
  logic [EMIT_BITS-1:0] ecnt_r, ecnt_nxt;

  logic                 ov_r, ov_nxt, otv_r, otv_nxt, olast_r, olast_nxt;
  logic                 ost_r, ost_nxt;
  logic signed [ACC_BITS-1:0] oc_r, oc_nxt;
  logic [POUT_BITS-1:0] op_r, op_nxt;

  logic                 wr_en, sh_en;
  logic [IW-1:0]        wr_idx, ra_idx, rb_idx;
  logic signed [CB-1:0] wr_c;
  logic [PB-1:0]        wr_p;

  logic signed [CB-1:0] ra_c, rb_c, rs_c;
  logic [PB-1:0]        ra_p, rb_p, rs_p;
  logic [CW-1:0]        scnt, shm1;
  logic signed [2*CB-1:0] prod;
  longint               c_ext, merge_ext, prod_ext, accsum;
  logic [23:0]          pin_ext;
  logic [31:0]          tgt_ext, spow_ext;
  logic signed [ACC_BITS-1:0] sum_c;
  logic [PB-1:0]        sum_p;
  logic                 take_a, take_b, i_end, j_end;

  assign shm1   = sh_r - CW'(1);
  assign ra_idx = (state_r == S_LSHIFT) ? shm1[IW-1:0] : i_r[IW-1:0];
  assign rb_idx = (state_r == S_LSHIFT) ? shm1[IW-1:0] :
                  (state_r == S_LSCAN)  ? i_r[IW-1:0] : j_r[IW-1:0];
  assign ra_c   = a_c_r[ra_idx];
  assign ra_p   = a_p_r[ra_idx];
  assign rb_c   = b_c_r[rb_idx];
  assign rb_p   = b_p_r[rb_idx];
  assign rs_c   = sel_r ? rb_c : ra_c;
  assign rs_p   = sel_r ? rb_p : ra_p;
  assign scnt   = sel_r ? bcnt_r : acnt_r;
  assign prod   = ra_c * rb_c;
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    acnt_nxt  = acnt_r;
    bcnt_nxt  = bcnt_r;
    sel_nxt   = sel_r;
    lc_nxt    = lc_r;
    lp_nxt    = lp_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    sh_nxt    = sh_r;
    mul_nxt   = mul_r;
    pp_nxt    = pp_r;
    acc_nxt   = acc_r;
    tgt_nxt   = tgt_r;
    nx_nxt    = nx_r;
    first_nxt = first_r;
    hit_nxt   = hit_r;
    nf_nxt    = nf_r;
    ecnt_nxt  = ecnt_r;
    ov_nxt    = 1'b0;
    otv_nxt   = 1'b0;
    olast_nxt = 1'b1;
    ost_nxt   = 1'b0;
    oc_nxt    = '0;
    op_nxt    = '0;
    wr_en     = 1'b0;
    sh_en     = 1'b0;
    wr_idx    = i_r[IW-1:0];
    wr_c      = lc_r;
    wr_p      = lp_r;
    pin_ext   = {16'd0, in_power_in};
    c_ext     = 64'(in_coeff_in);
    merge_ext = 64'(rs_c) + 64'(lc_r);
    prod_ext  = 64'(prod);
    accsum    = 64'(acc_r) + 64'(mul_r);
    tgt_ext   = 32'(tgt_r);
    i_end     = (i_r >= acnt_r);
    j_end     = (j_r >= bcnt_r);
    take_a    = 1'b0;
    take_b    = 1'b0;
    sum_c     = '0;
    sum_p     = '0;
    spow_ext  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          i_nxt     = '0;
          j_nxt     = '0;
          first_nxt = 1'b1;
          hit_nxt   = 1'b0;
          nf_nxt    = 1'b0;
          ecnt_nxt  = '0;
          sel_nxt   = (in_opcode == OP_LOAD_B);
          lp_nxt    = pin_ext[PB-1:0];
          if (c_ext > CHI)      lc_nxt = CB'(CHI);
          else if (c_ext < CLO) lc_nxt = CB'(CLO);
          else                  lc_nxt = CB'(c_ext);
          priority if ((in_opcode == OP_LOAD_A || in_opcode == OP_LOAD_B) &&
                       in_coeff_in != 16'sd0) begin
            state_nxt = S_LSCAN;
          end else if (in_opcode == OP_SUM && (acnt_r != '0 || bcnt_r != '0)) begin
            state_nxt = S_SUM;
          end else if (in_opcode == OP_PRODUCT && acnt_r != '0 && bcnt_r != '0) begin
            state_nxt = S_PMUL;
          end else begin
            if (in_opcode == OP_CLEAR) begin
              acnt_nxt = '0;
              bcnt_nxt = '0;
            end
            ov_nxt = 1'b1;
          end
        end
      end
      S_LSCAN: begin
        priority if (i_r < scnt && rs_p > lp_r) begin
          i_nxt = i_r + CW'(1);
        end else if (i_r < scnt && rs_p == lp_r) begin
          wr_en = 1'b1;
          if (merge_ext > CHI)      wr_c = CB'(CHI);
          else if (merge_ext < CLO) wr_c = CB'(CLO);
          else                      wr_c = CB'(merge_ext);
          wr_p      = rs_p;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if (32'(scnt) >= 32'(MAX_TERMS)) begin
          ov_nxt    = 1'b1;
          ost_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else if (scnt == i_r) begin
          state_nxt = S_LINS;
        end else begin
          sh_nxt    = scnt;
          state_nxt = S_LSHIFT;
        end
      end
      S_LSHIFT: begin
        sh_en  = 1'b1;
        wr_idx = sh_r[IW-1:0];
        wr_c   = rs_c;
        wr_p   = rs_p;
        sh_nxt = shm1;
        if (shm1 == i_r) state_nxt = S_LINS;
      end
      S_LINS: begin
        wr_en = 1'b1;
        if (sel_r) bcnt_nxt = bcnt_r + CW'(1);
        else       acnt_nxt = acnt_r + CW'(1);
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SUM: begin
        priority if (!i_end && !j_end && ra_p == rb_p) begin
          take_a = 1'b1;
          take_b = 1'b1;
        end else if (j_end || (!i_end && ra_p > rb_p)) begin
          take_a = 1'b1;
        end else begin
          take_b = 1'b1;
        end
        sum_c = (take_a ? ACC_BITS'(ra_c) : '0) + (take_b ? ACC_BITS'(rb_c) : '0);
        sum_p = take_a ? ra_p : rb_p;
        spow_ext = 32'(sum_p);
        if (take_a) i_nxt = i_r + CW'(1);
        if (take_b) j_nxt = j_r + CW'(1);
        ov_nxt    = 1'b1;
        otv_nxt   = 1'b1;
        oc_nxt    = sum_c;
        op_nxt    = spow_ext[POUT_BITS-1:0];
        olast_nxt = (i_nxt >= acnt_r) && (j_nxt >= bcnt_r);
        if (olast_nxt) state_nxt = S_IDLE;
      end
      S_PMUL: begin
        if (prod_ext > AHI)      mul_nxt = ACC_BITS'(AHI);
        else if (prod_ext < ALO) mul_nxt = ACC_BITS'(ALO);
        else                     mul_nxt = ACC_BITS'(prod_ext);
        pp_nxt    = PW'(ra_p) + PW'(rb_p);
        state_nxt = S_PACC;
      end
      S_PACC: begin
        if (!first_r && pp_r == tgt_r) begin
          hit_nxt = 1'b1;
          if (!hit_r)             acc_nxt = mul_r;
          else if (accsum > AHI)  acc_nxt = ACC_BITS'(AHI);
          else if (accsum < ALO)  acc_nxt = ACC_BITS'(ALO);
          else                    acc_nxt = ACC_BITS'(accsum);
        end else if ((first_r || pp_r < tgt_r) && (!nf_r || pp_r > nx_r)) begin
          nx_nxt = pp_r;
          nf_nxt = 1'b1;
        end
        state_nxt = S_PMUL;
        if (j_r + CW'(1) >= bcnt_r) begin
          j_nxt = '0;
          if (i_r + CW'(1) >= acnt_r) begin
            i_nxt     = '0;
            state_nxt = S_PEND;
          end else begin
            i_nxt = i_r + CW'(1);
          end
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      S_PEND: begin
        tgt_nxt   = nx_r;
        first_nxt = 1'b0;
        hit_nxt   = 1'b0;
        nf_nxt    = 1'b0;
        state_nxt = S_PMUL;
        if (!first_r) begin
          ov_nxt    = 1'b1;
          otv_nxt   = 1'b1;
          oc_nxt    = acc_r;
          op_nxt    = tgt_ext[POUT_BITS-1:0];
          olast_nxt = !nf_r || (ecnt_r == EMIT_BITS'(EMIT_LIMIT - 1));
          ecnt_nxt  = ecnt_r + EMIT_BITS'(1);
          if (olast_nxt) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acnt_r  <= '0;
      bcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acnt_r  <= acnt_nxt;
      bcnt_r  <= bcnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r   <= sel_nxt;
    lc_r    <= lc_nxt;
    lp_r    <= lp_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    sh_r    <= sh_nxt;
    mul_r   <= mul_nxt;
    pp_r    <= pp_nxt;
    acc_r   <= acc_nxt;
    tgt_r   <= tgt_nxt;
    nx_r    <= nx_nxt;
    first_r <= first_nxt;
    hit_r   <= hit_nxt;
    nf_r    <= nf_nxt;
    ecnt_r  <= ecnt_nxt;
    otv_r   <= otv_nxt;
    olast_r <= olast_nxt;
    ost_r   <= ost_nxt;
    oc_r    <= oc_nxt;
    op_r    <= op_nxt;
    if (wr_en || sh_en) begin
      if (sel_r) begin
        b_c_r[wr_idx] <= wr_c;
        b_p_r[wr_idx] <= wr_p;
      end else begin
        a_c_r[wr_idx] <= wr_c;
        a_p_r[wr_idx] <= wr_p;
      end
    end
  end

  assign out_valid      = ov_r;
  assign out_term_valid = otv_r;
  assign out_last_item  = olast_r;
  assign out_status     = ost_r;
  assign out_coeff_out  = oc_r;
  assign out_power_out  = op_r;

  a_term_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_term_valid |-> !out_status)
    else $error("term beat carries drop status");
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_term_valid |-> out_last_item)
    else $error("acknowledge beat not marked last");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_item |-> state_r == S_IDLE)
    else $error("busy after last beat");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(acnt_r) <= 32'(MAX_TERMS) && 32'(bcnt_r) <= 32'(MAX_TERMS))
    else $error("table count beyond capacity");

endmodule
